// ----- design/ogpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page framer package
// Shared constants, types and helper functions for the page framer.
// ----------------------------------------------------------------------------
package ogpf_pkg;

    localparam int          MAX_PACKET_DEF = 2048;
    localparam int          FIXED_HDR      = 27;
    localparam int          SEG_SIZE       = 255;
    localparam logic [31:0] CRC_POLY       = 32'h04c1_1db7;
    localparam logic [31:0] SERIAL_RST     = 32'h1234_5678;

    localparam int LEN_W     = 12;
    localparam int OFF_W     = 12;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // Kind of an input transfer, carried on s_tuser.
    localparam logic CMD_OPEN = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    // Capture pattern "OggS".
    localparam logic [7:0] CAP_0 = 8'h4f;
    localparam logic [7:0] CAP_1 = 8'h67;
    localparam logic [7:0] CAP_2 = 8'h67;
    localparam logic [7:0] CAP_3 = 8'h53;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR_CRC,
        ST_HDR_OUT
    } state_t;

    typedef struct packed {
        logic open;      // latch a new page header
        logic data;      // fold and forward one payload byte
        logic crc_step;  // fold one header byte into the CRC
        logic emit;      // present one header byte
        logic set_open;  // page now waits for payload
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic page_open;
        logic idx_last;
        logic len_zero;
        logic data_last;
    } dp_status_t;

    // One byte through the MSB-first CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    // Quotient by 255, exact for every LEN_W-bit input.
    function automatic logic [4:0] div255(input logic [LEN_W-1:0] x);
        logic [LEN_W:0] t;
        t = {1'b0, x} + (LEN_W+1)'(1) + (LEN_W+1)'(x >> 8);
        return 5'(t >> 8);
    endfunction

endpackage

`default_nettype wire

// ----- design/ogpf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page framer controller
// Sequences page open, header CRC folding, payload transfer and header output.
// ----------------------------------------------------------------------------
module ogpf_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,
    output logic                       s_tready,
    input  wire ogpf_pkg::dp_status_t  sts,
    output ogpf_pkg::ctrl_cmd_t        cmd
);

    ogpf_pkg::state_t state_reg, state_next;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ogpf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ogpf_pkg::ST_IDLE: begin
                s_tready = sts.out_free;
                accept   = s_tvalid & sts.out_free;
                if (accept) begin
                    if (s_tuser == ogpf_pkg::CMD_OPEN) begin
                        cmd.open   = 1'b1;
                        state_next = ogpf_pkg::ST_HDR_CRC;
                    end else if (sts.page_open) begin
                        cmd.data = 1'b1;
                        if (sts.data_last) begin
                            state_next = ogpf_pkg::ST_HDR_OUT;
                        end
                    end
                end
            end
            ogpf_pkg::ST_HDR_CRC: begin
                cmd.crc_step = 1'b1;
                if (sts.idx_last) begin
                    if (sts.len_zero) begin
                        state_next = ogpf_pkg::ST_HDR_OUT;
                    end else begin
                        cmd.set_open = 1'b1;
                        state_next   = ogpf_pkg::ST_IDLE;
                    end
                end
            end
            ogpf_pkg::ST_HDR_OUT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ogpf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ogpf_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.data) |-> sts.out_free)
        else $error("result loaded over a pending transfer");

    a_data_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.data |-> sts.page_open)
        else $error("payload byte forwarded with no page open");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.open, cmd.data, cmd.crc_step, cmd.emit}))
        else $error("conflicting datapath commands");

    // A non-empty page becomes open right after its header CRC.
    a_open_after_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ogpf_pkg::ST_HDR_CRC && sts.idx_last && !sts.len_zero)
        |=> (state_reg == ogpf_pkg::ST_IDLE && sts.page_open))
        else $error("page not open after header CRC");
`endif

endmodule

`default_nettype wire

// ----- design/ogpf_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page framer datapath
// Page header registers, CRC-32 register, counters and the output register.
// ----------------------------------------------------------------------------
module ogpf_datapath #(
    parameter int MAX_PACKET = ogpf_pkg::MAX_PACKET_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [ogpf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [31:0]                     cfg_wr_data,
    input  wire ogpf_pkg::ctrl_cmd_t             cmd,
    output ogpf_pkg::dp_status_t                 sts,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ogpf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int MAX_HLEN = ogpf_pkg::FIXED_HDR + MAX_PACKET / ogpf_pkg::SEG_SIZE + 1;
    localparam int HLEN_W   = $clog2(MAX_HLEN + 1);
    localparam int LEN_W    = ogpf_pkg::LEN_W;
    localparam int OFF_W    = ogpf_pkg::OFF_W;

    // Input fields
    logic [7:0]       in_flags;
    logic [63:0]      in_granule;
    logic [LEN_W-1:0] in_len;
    logic [7:0]       in_data;

    assign in_flags   = s_tdata[7:0];
    assign in_granule = s_tdata[71:8];
    assign in_len     = s_tdata[83:72];
    assign in_data    = s_tdata[91:84];

    // Control state
    logic [31:0]       serial_reg, serial_next;
    logic [31:0]       seq_reg, seq_next;
    logic [31:0]       crc_reg, crc_next;
    logic              open_reg, open_next;
    logic [HLEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  rcv_reg, rcv_next;
    logic              valid_reg, valid_next;

    // Page registers
    logic [7:0]        flags_reg;
    logic [63:0]       granule_reg;
    logic [31:0]       hserial_reg;
    logic [31:0]       cur_seq_reg;
    logic [LEN_W-1:0]  exp_len_reg;
    logic [HLEN_W-1:0] ns_reg;
    logic [HLEN_W-1:0] hlen_reg;
    logic [7:0]        rem_reg;

    logic [7:0]        obyte_reg;
    logic [OFF_W-1:0]  off_reg;
    logic              ohdr_reg;
    logic              olast_reg;

    // Length decode for a page open
    logic [LEN_W-1:0]  len_sat;
    logic [4:0]        len_q;
    logic [LEN_W:0]    len_r;
    logic [HLEN_W-1:0] ns_new;

    always_comb begin
        if (int'(in_len) > MAX_PACKET) begin
            len_sat = LEN_W'(MAX_PACKET);
        end else begin
            len_sat = in_len;
        end
        len_q  = ogpf_pkg::div255(len_sat);
        len_r  = {1'b0, len_sat} - (((LEN_W+1)'(len_q) << 8) - (LEN_W+1)'(len_q));
        ns_new = (len_sat == '0) ? '0 : HLEN_W'(len_q) + HLEN_W'(1);
    end

    // Header byte selected by idx_reg
    logic [31:0]       crc_fill;
    logic [HLEN_W-1:0] g_sel, w_sel, seg_sel;
    logic [7:0]        hdr_b;

    assign crc_fill = cmd.emit ? crc_reg : 32'h0;

    always_comb begin
        g_sel   = idx_reg - HLEN_W'(6);
        w_sel   = idx_reg - HLEN_W'(14);
        seg_sel = idx_reg - HLEN_W'(ogpf_pkg::FIXED_HDR - 1);
        if (int'(idx_reg) == 0) begin
            hdr_b = ogpf_pkg::CAP_0;
        end else if (int'(idx_reg) == 1) begin
            hdr_b = ogpf_pkg::CAP_1;
        end else if (int'(idx_reg) == 2) begin
            hdr_b = ogpf_pkg::CAP_2;
        end else if (int'(idx_reg) == 3) begin
            hdr_b = ogpf_pkg::CAP_3;
        end else if (int'(idx_reg) == 4) begin
            hdr_b = 8'h00;
        end else if (int'(idx_reg) == 5) begin
            hdr_b = flags_reg;
        end else if (int'(idx_reg) < 14) begin
            hdr_b = granule_reg[{g_sel[2:0], 3'b000} +: 8];
        end else if (int'(idx_reg) < 18) begin
            hdr_b = hserial_reg[{w_sel[1:0], 3'b000} +: 8];
        end else if (int'(idx_reg) < 22) begin
            hdr_b = cur_seq_reg[{w_sel[1:0], 3'b000} +: 8];
        end else if (int'(idx_reg) < 26) begin
            hdr_b = crc_fill[{w_sel[1:0], 3'b000} +: 8];
        end else if (int'(idx_reg) == 26) begin
            hdr_b = 8'(ns_reg);
        end else if (seg_sel < ns_reg) begin
            // Full segments; the last lacing value carries the remainder.
            hdr_b = 8'hff;
        end else begin
            hdr_b = rem_reg;
        end
    end

    logic out_free;
    logic idx_last;
    logic out_load;

    assign out_free = !valid_reg || m_tready;
    assign idx_last = (idx_reg == hlen_reg - HLEN_W'(1));
    assign out_load = cmd.data || cmd.emit;

    assign sts.out_free  = out_free;
    assign sts.page_open = open_reg;
    assign sts.idx_last  = idx_last;
    assign sts.len_zero  = (exp_len_reg == '0);
    assign sts.data_last = ({1'b0, rcv_reg} + (LEN_W+1)'(1)) >= {1'b0, exp_len_reg};

    always_comb begin
        serial_next = cfg_wr_en ? cfg_wr_data : serial_reg;
        seq_next    = seq_reg;
        crc_next    = crc_reg;
        open_next   = open_reg;
        idx_next    = idx_reg;
        rcv_next    = rcv_reg;
        if (cmd.open) begin
            seq_next  = seq_reg + 32'd1;
            crc_next  = '0;
            open_next = 1'b0;
            idx_next  = '0;
            rcv_next  = '0;
        end
        if (cmd.crc_step) begin
            crc_next = ogpf_pkg::crc_byte(crc_reg, hdr_b);
            idx_next = idx_last ? '0 : idx_reg + HLEN_W'(1);
        end
        if (cmd.set_open) begin
            open_next = 1'b1;
        end
        if (cmd.data) begin
            crc_next = ogpf_pkg::crc_byte(crc_reg, in_data);
            rcv_next = rcv_reg + LEN_W'(1);
            if (sts.data_last) begin
                open_next = 1'b0;
            end
        end
        if (cmd.emit) begin
            idx_next = idx_last ? '0 : idx_reg + HLEN_W'(1);
        end
        if (out_load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            serial_reg <= ogpf_pkg::SERIAL_RST;
            seq_reg    <= '0;
            crc_reg    <= '0;
            open_reg   <= 1'b0;
            idx_reg    <= '0;
            rcv_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            serial_reg <= serial_next;
            seq_reg    <= seq_next;
            crc_reg    <= crc_next;
            open_reg   <= open_next;
            idx_reg    <= idx_next;
            rcv_reg    <= rcv_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.open) begin
            flags_reg   <= in_flags;
            granule_reg <= in_granule;
            hserial_reg <= serial_reg;
            cur_seq_reg <= seq_reg;
            exp_len_reg <= len_sat;
            ns_reg      <= ns_new;
            hlen_reg    <= HLEN_W'(ogpf_pkg::FIXED_HDR) + ns_new;
            rem_reg     <= len_r[7:0];
        end
        if (cmd.data) begin
            obyte_reg <= in_data;
            off_reg   <= OFF_W'(hlen_reg) + rcv_reg;
            ohdr_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end else if (cmd.emit) begin
            obyte_reg <= hdr_b;
            off_reg   <= OFF_W'(idx_reg);
            ohdr_reg  <= 1'b1;
            olast_reg <= idx_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, off_reg, obyte_reg};
    assign m_tuser  = ohdr_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

// ----- design/ogg_page_framer_crc32_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Ogg page framer with CRC-32
// Wraps one packet per Ogg page and emits payload and header bytes.
// ----------------------------------------------------------------------------
// Usage: an input transfer with s_tuser = 0 opens a page from the flags,
// granule position and packet length in s_tdata; s_tuser = 1 delivers one
// payload byte. Each output transfer carries one page byte and its offset in
// the stored page; m_tuser marks header bytes and m_tlast the final header
// byte of a page. Payload bytes come out first, then the complete header.
// Timing: an open folds the header into the CRC one byte per cycle while
// s_tready is low. Payload bytes are taken one per cycle while the output
// register is free and appear on m_tdata in the following cycle. After the
// last payload byte, or after the header CRC of an empty page, the header
// leaves at one byte per cycle as m_tready allows, while s_tready is low.
// A single output register decouples the channels; when m_tready is low the
// result holds and no new input transfer is taken until it drains.
// Reset (synchronous, active low) closes any page, zeroes the page sequence
// and restores the serial to its default. cfg_wr_en writes the serial, which
// a page latches when it opens.
// ----------------------------------------------------------------------------
module ogg_page_framer_crc32_unit #(
    parameter int MAX_PACKET = ogpf_pkg::MAX_PACKET_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [31:0]                     cfg_wr_data,   // stream_serial
    // Input channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // header_flags[7:0], granule[71:8], packet_length[83:72],
    // data_byte[91:84], zero fill
    input  wire logic [ogpf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,       // cmd
    // Result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_byte[7:0], byte_offset[19:8], zero fill
    output logic [ogpf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tuser,       // is_header
    output logic                                 m_tlast        // page_done
);

    ogpf_pkg::ctrl_cmd_t  cmd;
    ogpf_pkg::dp_status_t sts;

    ogpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ogpf_datapath #(
        .MAX_PACKET (MAX_PACKET)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ogg page framer testbench
// Drives page opens and payload bytes into the framer and compares every page
// byte against a page assembler that tracks sequence, serial and CRC. Random
// handshake gaps on both channels and one long output stall are applied.
// ----------------------------------------------------------------------------

typedef struct {
    bit [7:0]  value;
    bit [11:0] offset;
    bit        is_header;
    bit        page_done;
} page_byte_t;

class ogg_page_scoreboard;
    bit [31:0]  serial;
    bit [31:0]  next_sequence;
    bit [31:0]  page_sequence;
    bit [31:0]  page_serial;
    bit [31:0]  page_crc;
    bit [11:0]  page_length;
    bit [11:0]  bytes_seen;
    bit [7:0]   page_flags;
    bit [63:0]  page_granule;
    bit         page_open;
    page_byte_t expected_page_bytes[$];
    int         errors;

    function new();
        serial        = ogpf_pkg::SERIAL_RST;
        next_sequence = 0;
        page_sequence = 0;
        page_serial   = 0;
        page_crc      = 0;
        page_length   = 0;
        bytes_seen    = 0;
        page_flags    = 0;
        page_granule  = 0;
        page_open     = 0;
        errors        = 0;
    endfunction

    function int pending();
        return expected_page_bytes.size();
    endfunction

    function void report(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endfunction

    // MSB-first CRC-32, one bit per iteration.
    function bit [31:0] fold_crc(bit [31:0] crc, bit [7:0] b);
        bit [31:0] c;
        bit        top;
        c = crc ^ {b, 24'h0};
        repeat (8) begin
            top = c[31];
            c   = c << 1;
            if (top) begin
                c = c ^ ogpf_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function int lacing_segments();
        return (page_length == 0) ? 0 : page_length / ogpf_pkg::SEG_SIZE + 1;
    endfunction

    function bit [7:0] header_byte(int i, bit [31:0] crc);
        int nseg;
        nseg = lacing_segments();
        if (i == 0) return ogpf_pkg::CAP_0;
        if (i == 1) return ogpf_pkg::CAP_1;
        if (i == 2) return ogpf_pkg::CAP_2;
        if (i == 3) return ogpf_pkg::CAP_3;
        if (i == 4) return 8'h00;
        if (i == 5) return page_flags;
        if (i < 14) return page_granule[(i - 6) * 8 +: 8];
        if (i < 18) return page_serial[(i - 14) * 8 +: 8];
        if (i < 22) return page_sequence[(i - 18) * 8 +: 8];
        if (i < 26) return crc[(i - 22) * 8 +: 8];
        if (i == 26) return 8'(nseg);
        // Full segments first; the last lacing value holds the remainder,
        // which is zero when the length is a whole number of segments.
        if (i - ogpf_pkg::FIXED_HDR + 1 < nseg) return 8'hff;
        return 8'(page_length % ogpf_pkg::SEG_SIZE);
    endfunction

    function void push_byte(bit [7:0] v, int off, bit hdr, bit done);
        page_byte_t e;
        e.value     = v;
        e.offset    = 12'(off);
        e.is_header = hdr;
        e.page_done = done;
        expected_page_bytes.push_back(e);
    endfunction

    function void emit_header();
        int hlen;
        hlen = ogpf_pkg::FIXED_HDR + lacing_segments();
        for (int i = 0; i < hlen; i++) begin
            push_byte(header_byte(i, page_crc), i, 1'b1, i == hlen - 1);
        end
        page_open = 0;
    endfunction

    function void note_input(bit cmd, bit [95:0] d);
        bit [11:0] len;
        bit [7:0]  b;
        int        hlen;
        if (cmd == ogpf_pkg::CMD_OPEN) begin
            len = d[83:72];
            if (len > ogpf_pkg::MAX_PACKET_DEF) begin
                len = ogpf_pkg::MAX_PACKET_DEF;
            end
            // A page still open is dropped; its sequence number stays used.
            page_flags    = d[7:0];
            page_granule  = d[71:8];
            page_serial   = serial;
            page_length   = len;
            bytes_seen    = 0;
            page_sequence = next_sequence;
            next_sequence = next_sequence + 1;
            hlen          = ogpf_pkg::FIXED_HDR + lacing_segments();
            page_crc      = 0;
            for (int i = 0; i < hlen; i++) begin
                page_crc = fold_crc(page_crc, header_byte(i, 32'h0));
            end
            page_open = 1;
            if (len == 0) begin
                emit_header();
            end
        end else if (page_open) begin
            b        = d[91:84];
            hlen     = ogpf_pkg::FIXED_HDR + lacing_segments();
            page_crc = fold_crc(page_crc, b);
            push_byte(b, hlen + bytes_seen, 1'b0, 1'b0);
            bytes_seen = bytes_seen + 1;
            if (bytes_seen >= page_length) begin
                emit_header();
            end
        end
    endfunction

    function void check_output(bit [23:0] tdata, bit hdr, bit last);
        page_byte_t e;
        if (expected_page_bytes.size() == 0) begin
            report($sformatf("unexpected byte %h offset %0d header %b last %b",
                             tdata[7:0], tdata[19:8], hdr, last));
            return;
        end
        e = expected_page_bytes.pop_front();
        if (tdata[7:0] != e.value || tdata[19:8] != e.offset ||
            hdr != e.is_header || last != e.page_done) begin
            report($sformatf("expected %h off %0d hdr %b last %b, got %h off %0d hdr %b last %b",
                             e.value, e.offset, e.is_header, e.page_done,
                             tdata[7:0], tdata[19:8], hdr, last));
        end
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 80;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [31:0]                    cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    // header_flags[7:0], granule[71:8], packet_length[83:72],
    // data_byte[91:84], zero fill
    logic [ogpf_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic                           s_tuser     = 1'b0;   // cmd
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    // out_byte[7:0], byte_offset[19:8], zero fill
    logic [ogpf_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;              // is_header
    logic                           m_tlast;              // page_done

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    int  phase          = 0;
    int  cycle_count    = 0;
    int  items_sent     = 0;
    bit  hold_done      = 0;
    bit  page_left_open = 0;

    ogg_page_scoreboard sb;

    always #10 aclk = ~aclk;

    ogg_page_framer_crc32_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Results are checked before the input of the same edge is noted, so a
    // result can never match an expectation created at the same transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_output(m_tdata, m_tuser, m_tlast);
            end
            if (s_tvalid && s_tready) begin
                sb.note_input(s_tuser, s_tdata);
            end
        end
    end

    // Output side: random ready, plus one long hold-off when the last phase
    // starts so that the framer backs up into its input.
    initial begin
        int held;
        forever begin
            @(posedge aclk);
            if (phase == 3 && !hold_done) begin
                hold_done = 1;
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [95:0] open_word(logic [7:0] flags, logic [63:0] gran,
                                               logic [11:0] len);
        return {4'h0, 8'($urandom), len, gran, flags};
    endfunction

    function automatic logic [95:0] byte_word(logic [7:0] b);
        return {4'h0, b, 12'($urandom), {$urandom, $urandom}, 8'($urandom)};
    endfunction

    task automatic send_item(input logic cmd, input logic [95:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_page(input logic [7:0] flags, input logic [63:0] gran,
                             input logic [11:0] len);
        int n;
        n = (len > ogpf_pkg::MAX_PACKET_DEF) ? ogpf_pkg::MAX_PACKET_DEF : len;
        send_item(ogpf_pkg::CMD_OPEN, open_word(flags, gran, len));
        repeat (n) send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        items_sent += 1 + n;
    endtask

    // Waits for every expected byte, then lets a header CRC pass finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_serial(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.serial = v;
    endtask

    task automatic run_random(input int n_items);
        int         target;
        int         r;
        int         len;
        int         n;
        int         k;
        logic [7:0] f;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 8 && !page_left_open) begin
                // Stray byte with no page open; the framer drops it.
                send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
                items_sent += 1;
            end else if (r < 18) begin
                // Broken page: fewer bytes than announced, then a new open.
                len = $urandom_range(4095, 1);
                n   = (len > ogpf_pkg::MAX_PACKET_DEF) ? ogpf_pkg::MAX_PACKET_DEF : len;
                k   = $urandom_range((n > 6) ? 5 : n - 1, 0);
                send_item(ogpf_pkg::CMD_OPEN,
                          open_word(8'($urandom), {$urandom, $urandom}, 12'(len)));
                repeat (k) send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
                items_sent += 1 + k;
                page_left_open = 1;
            end else begin
                case ($urandom_range(3))
                    0:       f = 8'h00;
                    1:       f = 8'h02;
                    2:       f = 8'h04;
                    default: f = 8'($urandom);
                endcase
                len = ($urandom_range(19) == 0) ? $urandom_range(80, 13) : $urandom_range(12, 0);
                send_page(f, {$urandom, $urandom}, 12'(len));
                page_left_open = 0;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty page under the reset serial, a stray byte, field
        // extremes, reopen while open and a serial change inside a page.
        send_page(8'h00, 64'h0, 12'd0);
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'h5a));
        send_item(ogpf_pkg::CMD_OPEN, open_word(8'hff, 64'h7fff_ffff_ffff_ffff, 12'd1));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'hff));
        send_item(ogpf_pkg::CMD_OPEN, open_word(8'h02, 64'h8000_0000_0000_0000, 12'd2));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'h00));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        settle();
        write_serial(32'h0000_0000);
        send_page(8'h04, 64'hffff_ffff_ffff_ffff, 12'd0);
        send_item(ogpf_pkg::CMD_OPEN, open_word(8'h00, {$urandom, $urandom}, 12'd5));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        send_page(8'h00, {$urandom, $urandom}, 12'd3);
        send_item(ogpf_pkg::CMD_OPEN, open_word(8'h00, {$urandom, $urandom}, 12'd2));
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        settle();
        write_serial(32'hffff_ffff);
        send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        settle();

        phase         = 1;
        send_idle_pct = 37;
        recv_idle_pct = 68;
        write_serial($urandom);
        run_random(70);
        settle();

        phase         = 2;
        send_idle_pct = 68;
        recv_idle_pct = 37;
        write_serial($urandom);
        run_random(70);
        settle();

        // Oversized length saturates to the largest page; the offsets of the
        // few bytes that follow show the saturated lacing size. The output
        // side is held off meanwhile.
        phase         = 3;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_serial($urandom);
        send_item(ogpf_pkg::CMD_OPEN, open_word(8'($urandom), {$urandom, $urandom}, 12'hfff));
        repeat (3) send_item(ogpf_pkg::CMD_BYTE, byte_word(8'($urandom)));
        items_sent += 4;
        page_left_open = 1;
        run_random(66);
        settle();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- ogg_page_framer_crc32_unit.f -----
design/ogpf_pkg.sv
design/ogpf_ctrl.sv
design/ogpf_datapath.sv
design/ogg_page_framer_crc32_unit.sv
dv/testbench.sv
